// ===== rtl/vox_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vox_pkg;

	// Chunk dimensions.
	localparam int DIM_X = 16;
	localparam int DIM_Y = 16;
	localparam int DIM_Z = 16;

	localparam int DEPTH  = DIM_X * DIM_Y * DIM_Z;
	localparam int ADDR_W = $clog2(DEPTH);

	// Input coordinates are four bits; neighbor coordinates need one more bit for x + 1.
	localparam int POS_W   = 4;
	localparam int COORD_W = POS_W + 1;

	// Width wide enough to compare a coordinate against any dimension.
	localparam int CMP_W = 10;
	localparam logic [CMP_W-1:0] DIM_X_C = CMP_W'(DIM_X);
	localparam logic [CMP_W-1:0] DIM_Y_C = CMP_W'(DIM_Y);
	localparam logic [CMP_W-1:0] DIM_Z_C = CMP_W'(DIM_Z);

	localparam logic [1:0] KIND_AIR   = 2'd0;
	localparam logic [1:0] KIND_WATER = 2'd1;
	localparam logic [1:0] KIND_SOLID = 2'd2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		NB_XP,
		NB_XM,
		NB_YP,
		NB_YM,
		NB_ZP,
		NB_ZM
	} nbr_t;

	typedef struct packed {
		logic clear;
		logic wr;
		logic load;
		logic rd;
		nbr_t nbr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} status_t;

	function automatic addr_t cell_index(input coord_t x, input coord_t y, input coord_t z);
		cell_index = ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(DIM_X)
			+ ADDR_W'(z) * ADDR_W'(DIM_X * DIM_Y);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/vox_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vox_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [3:0] pos_x;
	logic [3:0] pos_y;
	logic [3:0] pos_z;
	logic [1:0] voxel_kind;

	modport source (output valid, mode, pos_x, pos_y, pos_z, voxel_kind, input ready);
	modport sink (input valid, mode, pos_x, pos_y, pos_z, voxel_kind, output ready);
endinterface

`default_nettype wire

// ===== rtl/vox_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vox_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

// ===== rtl/vox_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vox_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vox_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vox_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_mode,
	output logic                  in_ready,
	input  wire vox_pkg::status_t status,
	output vox_pkg::cmd_t         cmd
);

	vox_pkg::state_t state_q, state_d;
	vox_pkg::nbr_t   nbr_q, nbr_d;
	logic            fire;

	assign fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vox_pkg::ST_CLEAR;
			nbr_q   <= vox_pkg::NB_XP;
		end else begin
			state_q <= state_d;
			nbr_q   <= nbr_d;
		end
	end

	// Next state and neighbor step.
	always_comb begin
		state_d = state_q;
		nbr_d   = nbr_q;
		case (state_q)
			vox_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = vox_pkg::ST_IDLE;
				end
			end
			vox_pkg::ST_IDLE: begin
				if (fire && in_mode == vox_pkg::MODE_QUERY) begin
					state_d = vox_pkg::ST_SCAN;
					nbr_d   = vox_pkg::NB_XP;
				end
			end
			vox_pkg::ST_SCAN: begin
				case (nbr_q)
					vox_pkg::NB_XP: nbr_d = vox_pkg::NB_XM;
					vox_pkg::NB_XM: nbr_d = vox_pkg::NB_YP;
					vox_pkg::NB_YP: nbr_d = vox_pkg::NB_YM;
					vox_pkg::NB_YM: nbr_d = vox_pkg::NB_ZP;
					vox_pkg::NB_ZP: nbr_d = vox_pkg::NB_ZM;
					default: begin
						nbr_d   = vox_pkg::NB_XP;
						state_d = vox_pkg::ST_FINISH;
					end
				endcase
			end
			vox_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_d = vox_pkg::ST_IDLE;
				end
			end
			default: state_d = vox_pkg::ST_CLEAR;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.nbr   = nbr_q;
		case (state_q)
			vox_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			vox_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr   = in_valid && in_mode == vox_pkg::MODE_WRITE;
				cmd.load = in_valid && in_mode == vox_pkg::MODE_QUERY;
			end
			vox_pkg::ST_SCAN: begin
				cmd.rd = 1'b1;
			end
			vox_pkg::ST_FINISH: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/vox_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vox_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vox_pkg::cmd_t cmd,
	output vox_pkg::status_t   status,
	input  wire logic [3:0]    pos_x,
	input  wire logic [3:0]    pos_y,
	input  wire logic [3:0]    pos_z,
	input  wire logic [1:0]    voxel_kind,
	input  wire logic          out_ready,
	output logic               out_valid,
	output logic               visible
);

	vox_pkg::addr_t  clr_q;
	vox_pkg::coord_t in_x, in_y, in_z;
	vox_pkg::addr_t  in_idx;
	logic            in_inside;
	logic [1:0]      wr_kind;

	logic [3:0]      x_q, y_q, z_q;
	logic            inside_q;
	logic [1:0]      self_q;
	logic            any_air_q, any_water_q;
	logic            pend_self_s1, pend_nb_s1;
	logic            out_valid_q, visible_q;

	vox_pkg::coord_t nx, ny, nz;
	logic            nb_ok;
	vox_pkg::addr_t  nb_idx;

	logic            ram_we, ram_re;
	vox_pkg::addr_t  ram_addr;
	logic [1:0]      ram_wdata, ram_rdata;

	logic            air_c, water_c, vis_c;

	assign in_x      = {1'b0, pos_x};
	assign in_y      = {1'b0, pos_y};
	assign in_z      = {1'b0, pos_z};
	assign in_idx    = vox_pkg::cell_index(in_x, in_y, in_z);
	assign in_inside = vox_pkg::CMP_W'(pos_x) < vox_pkg::DIM_X_C
		&& vox_pkg::CMP_W'(pos_y) < vox_pkg::DIM_Y_C
		&& vox_pkg::CMP_W'(pos_z) < vox_pkg::DIM_Z_C;
	assign wr_kind   = (voxel_kind > vox_pkg::KIND_SOLID) ? vox_pkg::KIND_SOLID : voxel_kind;

	// Neighbor selection; a neighbor beyond the chunk edge is skipped.
	always_comb begin
		nx    = {1'b0, x_q};
		ny    = {1'b0, y_q};
		nz    = {1'b0, z_q};
		nb_ok = 1'b0;
		case (cmd.nbr)
			vox_pkg::NB_XP: begin
				nx    = {1'b0, x_q} + vox_pkg::COORD_W'(1);
				nb_ok = vox_pkg::CMP_W'(nx) < vox_pkg::DIM_X_C;
			end
			vox_pkg::NB_XM: begin
				nx    = {1'b0, x_q} - vox_pkg::COORD_W'(1);
				nb_ok = x_q != '0;
			end
			vox_pkg::NB_YP: begin
				ny    = {1'b0, y_q} + vox_pkg::COORD_W'(1);
				nb_ok = vox_pkg::CMP_W'(ny) < vox_pkg::DIM_Y_C;
			end
			vox_pkg::NB_YM: begin
				ny    = {1'b0, y_q} - vox_pkg::COORD_W'(1);
				nb_ok = y_q != '0;
			end
			vox_pkg::NB_ZP: begin
				nz    = {1'b0, z_q} + vox_pkg::COORD_W'(1);
				nb_ok = vox_pkg::CMP_W'(nz) < vox_pkg::DIM_Z_C;
			end
			vox_pkg::NB_ZM: begin
				nz    = {1'b0, z_q} - vox_pkg::COORD_W'(1);
				nb_ok = z_q != '0;
			end
			default: nb_ok = 1'b0;
		endcase
	end

	assign nb_idx = vox_pkg::cell_index(nx, ny, nz);

	// Memory port sharing: clearing, item writes, self read, neighbor reads.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = nb_idx;
		ram_wdata = wr_kind;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = vox_pkg::KIND_AIR;
		end else if (cmd.wr) begin
			ram_we   = in_inside;
			ram_addr = in_idx;
		end else if (cmd.load) begin
			ram_re   = in_inside;
			ram_addr = in_idx;
		end else if (cmd.rd) begin
			ram_re = nb_ok && inside_q;
		end
	end

	vox_ram #(
		.WIDTH(2),
		.DEPTH(vox_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			pend_self_s1 <= 1'b0;
			pend_nb_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + vox_pkg::ADDR_W'(1);
			end
			pend_self_s1 <= cmd.load;
			pend_nb_s1   <= cmd.rd && nb_ok && inside_q;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q         <= pos_x;
			y_q         <= pos_y;
			z_q         <= pos_z;
			inside_q    <= in_inside;
			any_air_q   <= 1'b0;
			any_water_q <= 1'b0;
		end else if (pend_nb_s1) begin
			any_air_q   <= air_c;
			any_water_q <= water_c;
		end
		if (pend_self_s1) begin
			self_q <= ram_rdata;
		end
		if (cmd.emit) begin
			visible_q <= vis_c;
		end
	end

	// The last neighbor's data is still on the read port when the result is formed.
	assign air_c   = any_air_q || (pend_nb_s1 && ram_rdata == vox_pkg::KIND_AIR);
	assign water_c = any_water_q || (pend_nb_s1 && ram_rdata == vox_pkg::KIND_WATER);
	assign vis_c   = inside_q && self_q != vox_pkg::KIND_AIR
		&& (air_c || (self_q != vox_pkg::KIND_WATER && water_c));

	assign status.clear_last = clr_q == vox_pkg::ADDR_W'(vox_pkg::DEPTH - 1);
	assign status.out_free   = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign visible           = visible_q;

endmodule

`default_nettype wire

// ===== rtl/voxel_occlusion_query.sv =====
// Voxel chunk store with six-neighbor occlusion queries. Each beat on the item
// channel either writes one voxel type (air, water or solid; code three stores
// solid) or queries whether a voxel is visible: non-air and with at least one
// in-chunk face neighbor that is air, or, for a voxel that is not water, at
// least one that is water. Writes give no result beat; each query gives one beat
// on the result channel, and a position outside the chunk answers not visible.
// All voxel types live in one single-port memory, so the port sets the rate: a
// write is taken at once while the block is idle; a query reads the voxel itself
// as it is accepted, then the six neighbors one at a time, then forms the answer.
// A result waiting in the output register does not hold up writes; a following
// query waits in its answer step until that result is taken. After reset the
// block clears the memory to air, one entry a cycle, and takes no item until all
// DEPTH entries (4096 with a 16 by 16 by 16 chunk) are cleared; no item is taken while a query is in progress.
`timescale 1ns / 1ps
`default_nettype none

module voxel_occlusion_query (
	input  wire logic clk,
	input  wire logic arst_n,
	vox_in_if.sink    item,
	vox_out_if.source result
);

	vox_pkg::cmd_t    cmd;
	vox_pkg::status_t status;

	// The controller sequences clearing, writes and the voxel read and up to six neighbor reads of a query.
	vox_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_mode (item.mode),
		.in_ready(item.ready),
		.status  (status),
		.cmd     (cmd)
	);

	// The datapath owns the memory, the neighbor addressing and the result register.
	vox_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pos_x     (item.pos_x),
		.pos_y     (item.pos_y),
		.pos_z     (item.pos_z),
		.voxel_kind(item.voxel_kind),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.visible   (result.visible)
	);

	// Once a query is taken, no further item is accepted in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !item.ready)
		else $error("item accepted right after a query");

	// Forming an answer always presents a result beat in the next cycle.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result.valid)
		else $error("answer formed but no result beat presented");

	// The memory port serves at most one command per cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.wr, cmd.load, cmd.rd, cmd.emit}))
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire
